/* rtl/core/hid_report_to_key_matrix_assert.svh */
// Assertion macros for the HID report to key matrix converter.
// Depends on clk and rst_n being visible in the module that uses them.
`ifndef HID_REPORT_TO_KEY_MATRIX_ASSERT_SVH
`define HID_REPORT_TO_KEY_MATRIX_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define HRKM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hrkm assertion failed");

// Check that the consequent holds in the cycle after the antecedent.
`define HRKM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hrkm assertion failed");

`endif

/* rtl/core/hrkm_pkg.sv */
// Shared types, constants and the key ROM for the HID report to key matrix converter.
// No dependencies.
package hrkm_pkg;

  localparam int ROW_COUNT = 8;
  localparam int ROW_W     = 8;
  localparam int CODE_W    = 8;
  localparam int KEY_SLOTS = 6;
  localparam int ROW_IDX_W = $clog2(ROW_COUNT);

  typedef logic [ROW_W-1:0]     row_t;
  typedef logic [CODE_W-1:0]    code_t;
  typedef logic [ROW_IDX_W-1:0] row_idx_t;
  typedef row_t [ROW_COUNT-1:0] row_set_t;

  typedef enum logic [1:0] {
    SEC_NONE = 2'd0,
    SEC_CAPS = 2'd1,
    SEC_SYM  = 2'd2
  } sec_t;

  typedef struct packed {
    logic     hit;
    row_idx_t row;
    row_t     mask;
    sec_t     sec;
  } rom_ent_t;

  localparam row_t     ROW_IDLE  = 8'hFF;
  localparam row_idx_t CAPS_ROW  = 3'd7;
  localparam row_t     CAPS_MASK = 8'hFE;
  localparam row_idx_t SYM_ROW   = 3'd0;
  localparam row_t     SYM_MASK  = 8'hFD;

  // HID modifier byte positions
  localparam int MOD_LCTRL  = 0;
  localparam int MOD_LSHIFT = 1;
  localparam int MOD_RCTRL  = 4;
  localparam int MOD_RSHIFT = 5;

  // Remap ranges
  localparam code_t DIGIT_LO  = 8'h1E;
  localparam code_t DIGIT_HI  = 8'h27;
  localparam code_t DIGIT_OFS = 8'hCA;  // 0x1E -> 0xE8
  localparam code_t PUNCT_LO  = 8'h2D;
  localparam code_t PUNCT_HI  = 8'h38;
  localparam code_t PUNCT_OFS = 8'hC5;  // 0x2D -> 0xF2
  localparam code_t KPAD_LO   = 8'h59;
  localparam code_t KPAD_HI   = 8'h63;
  localparam code_t KPAD_OFS  = 8'h4C;  // 0x59 -> 0xA5

  function automatic rom_ent_t rom_mk(input row_idx_t row, input row_t mask, input sec_t sec);
    rom_ent_t e;
    e.hit  = 1'b1;
    e.row  = row;
    e.mask = mask;
    e.sec  = sec;
    return e;
  endfunction

  function automatic rom_ent_t rom_lookup(input code_t code);
    rom_ent_t e;
    e = '{hit: 1'b0, row: '0, mask: ROW_IDLE, sec: SEC_NONE};
    unique case (code)
      8'h00: e = rom_mk(3'd0, 8'hFF, SEC_NONE);
      8'h04: e = rom_mk(3'd6, 8'hFE, SEC_NONE);
      8'h05: e = rom_mk(3'd0, 8'hEF, SEC_NONE);
      8'h06: e = rom_mk(3'd7, 8'hF7, SEC_NONE);
      8'h07: e = rom_mk(3'd6, 8'hFB, SEC_NONE);
      8'h08: e = rom_mk(3'd5, 8'hFB, SEC_NONE);
      8'h09: e = rom_mk(3'd6, 8'hF7, SEC_NONE);
      8'h0A: e = rom_mk(3'd6, 8'hEF, SEC_NONE);
      8'h0B: e = rom_mk(3'd1, 8'hEF, SEC_NONE);
      8'h0C: e = rom_mk(3'd2, 8'hFB, SEC_NONE);
      8'h0D: e = rom_mk(3'd1, 8'hF7, SEC_NONE);
      8'h0E: e = rom_mk(3'd1, 8'hFB, SEC_NONE);
      8'h0F: e = rom_mk(3'd1, 8'hFD, SEC_NONE);
      8'h10: e = rom_mk(3'd0, 8'hFB, SEC_NONE);
      8'h11: e = rom_mk(3'd0, 8'hF7, SEC_NONE);
      8'h12: e = rom_mk(3'd2, 8'hFD, SEC_NONE);
      8'h13: e = rom_mk(3'd2, 8'hFE, SEC_NONE);
      8'h14: e = rom_mk(3'd5, 8'hFE, SEC_NONE);
      8'h15: e = rom_mk(3'd5, 8'hF7, SEC_NONE);
      8'h16: e = rom_mk(3'd6, 8'hFD, SEC_NONE);
      8'h17: e = rom_mk(3'd5, 8'hEF, SEC_NONE);
      8'h18: e = rom_mk(3'd2, 8'hF7, SEC_NONE);
      8'h19: e = rom_mk(3'd7, 8'hEF, SEC_NONE);
      8'h1A: e = rom_mk(3'd5, 8'hFD, SEC_NONE);
      8'h1B: e = rom_mk(3'd7, 8'hFB, SEC_NONE);
      8'h1C: e = rom_mk(3'd2, 8'hEF, SEC_NONE);
      8'h1D: e = rom_mk(3'd7, 8'hFD, SEC_NONE);
      8'h1E: e = rom_mk(3'd4, 8'hFE, SEC_NONE);
      8'h1F: e = rom_mk(3'd4, 8'hFD, SEC_NONE);
      8'h20: e = rom_mk(3'd4, 8'hFB, SEC_NONE);
      8'h21: e = rom_mk(3'd4, 8'hF7, SEC_NONE);
      8'h22: e = rom_mk(3'd4, 8'hEF, SEC_NONE);
      8'h23: e = rom_mk(3'd3, 8'hEF, SEC_NONE);
      8'h24: e = rom_mk(3'd3, 8'hF7, SEC_NONE);
      8'h25: e = rom_mk(3'd3, 8'hFB, SEC_NONE);
      8'h26: e = rom_mk(3'd3, 8'hFD, SEC_NONE);
      8'h27: e = rom_mk(3'd3, 8'hFE, SEC_NONE);
      8'h28: e = rom_mk(3'd1, 8'hFE, SEC_NONE);
      8'h2A: e = rom_mk(3'd3, 8'hFE, SEC_CAPS);
      8'h2C: e = rom_mk(3'd0, 8'hFE, SEC_NONE);
      8'h2D: e = rom_mk(3'd1, 8'hF7, SEC_SYM);
      8'h2E: e = rom_mk(3'd1, 8'hFD, SEC_SYM);
      8'h2F: e = rom_mk(3'd2, 8'hEF, SEC_SYM);
      8'h30: e = rom_mk(3'd2, 8'hF7, SEC_SYM);
      8'h32: e = rom_mk(3'd2, 8'hFE, SEC_SYM);
      8'h33: e = rom_mk(3'd2, 8'hFD, SEC_SYM);
      8'h34: e = rom_mk(3'd3, 8'hF7, SEC_SYM);
      8'h35: e = rom_mk(3'd7, 8'hFB, SEC_SYM);
      8'h36: e = rom_mk(3'd0, 8'hF7, SEC_SYM);
      8'h37: e = rom_mk(3'd0, 8'hFB, SEC_SYM);
      8'h38: e = rom_mk(3'd7, 8'hEF, SEC_SYM);
      8'h4B: e = rom_mk(3'd0, 8'hFE, SEC_CAPS);
      8'h4F: e = rom_mk(3'd3, 8'hFB, SEC_CAPS);
      8'h50: e = rom_mk(3'd4, 8'hEF, SEC_CAPS);
      8'h51: e = rom_mk(3'd3, 8'hEF, SEC_CAPS);
      8'h52: e = rom_mk(3'd3, 8'hF7, SEC_CAPS);
      8'h54: e = rom_mk(3'd7, 8'hEF, SEC_SYM);
      8'h55: e = rom_mk(3'd0, 8'hEF, SEC_SYM);
      8'h56: e = rom_mk(3'd1, 8'hF7, SEC_SYM);
      8'h57: e = rom_mk(3'd1, 8'hFB, SEC_SYM);
      8'h58: e = rom_mk(3'd1, 8'hFE, SEC_NONE);
      8'hE8: e = rom_mk(3'd4, 8'hFE, SEC_SYM);
      8'hE9: e = rom_mk(3'd4, 8'hFD, SEC_SYM);
      8'hEA: e = rom_mk(3'd4, 8'hFB, SEC_SYM);
      8'hEB: e = rom_mk(3'd4, 8'hF7, SEC_SYM);
      8'hEC: e = rom_mk(3'd4, 8'hEF, SEC_SYM);
      8'hED: e = rom_mk(3'd1, 8'hEF, SEC_SYM);
      8'hEE: e = rom_mk(3'd3, 8'hEF, SEC_SYM);
      8'hEF: e = rom_mk(3'd0, 8'hEF, SEC_SYM);
      8'hF0: e = rom_mk(3'd3, 8'hFB, SEC_SYM);
      8'hF1: e = rom_mk(3'd3, 8'hFD, SEC_SYM);
      8'hF2: e = rom_mk(3'd3, 8'hFE, SEC_SYM);
      8'hF3: e = rom_mk(3'd1, 8'hFB, SEC_SYM);
      8'hF4: e = rom_mk(3'd6, 8'hF7, SEC_SYM);
      8'hF5: e = rom_mk(3'd6, 8'hEF, SEC_SYM);
      8'hF7: e = rom_mk(3'd6, 8'hFD, SEC_SYM);
      8'hF8: e = rom_mk(3'd7, 8'hFD, SEC_SYM);
      8'hF9: e = rom_mk(3'd2, 8'hFE, SEC_SYM);
      8'hFA: e = rom_mk(3'd6, 8'hFE, SEC_SYM);
      8'hFB: e = rom_mk(3'd5, 8'hF7, SEC_SYM);
      8'hFC: e = rom_mk(3'd0, 8'hFB, SEC_SYM);
      8'hFD: e = rom_mk(3'd7, 8'hF7, SEC_SYM);
      default: e.hit = 1'b0;
    endcase
    return e;
  endfunction

endpackage

/* rtl/core/hrkm_lane.sv */
// One key lane: remaps a HID code, looks it up in the key ROM and gives its row masks.
// Depends on hrkm_pkg.
module hrkm_lane
  import hrkm_pkg::*;
(
  input  logic     lane_en,
  input  code_t    key_code,
  input  logic     shift,
  input  logic     num_lock,
  input  row_t     column_mask,
  output row_set_t lane_rows
);

  code_t    code_map;
  rom_ent_t ent;

  always_comb begin
    code_map = key_code;
    if (shift) begin
      if (key_code >= DIGIT_LO && key_code <= DIGIT_HI) begin
        code_map = key_code + DIGIT_OFS;
      end else if (key_code >= PUNCT_LO && key_code <= PUNCT_HI) begin
        code_map = key_code + PUNCT_OFS;
      end
    end else if (num_lock && key_code >= KPAD_LO && key_code <= KPAD_HI) begin
      code_map = key_code + KPAD_OFS;
    end

    ent = rom_lookup(code_map);

    lane_rows = '1;
    if (lane_en && ent.hit) begin
      lane_rows[ent.row] = lane_rows[ent.row] & ent.mask & column_mask;
      case (ent.sec)
        SEC_CAPS: lane_rows[CAPS_ROW] = lane_rows[CAPS_ROW] & CAPS_MASK & column_mask;
        SEC_SYM:  lane_rows[SYM_ROW]  = lane_rows[SYM_ROW] & SYM_MASK & column_mask;
        default:  ;
      endcase
    end
  end

endmodule

/* rtl/core/hrkm_merge.sv */
// Merge stage: ANDs the lane and modifier row masks and registers the result.
// Depends on hrkm_pkg.
module hrkm_merge
  import hrkm_pkg::*;
#(
  parameter int LANES = 6
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_vld,
  input  row_set_t mod_rows,
  input  row_set_t lane_rows [LANES],
  output logic     out_vld,
  output row_set_t out_rows
);

  row_set_t rows_nxt;
  row_set_t rows_r;
  logic     vld_r;

  always_comb begin
    rows_nxt = mod_rows;
    for (int i = 0; i < LANES; i++) begin
      rows_nxt = rows_nxt & lane_rows[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld) begin
      rows_r <= rows_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_rows = rows_r;

endmodule

/* rtl/core/hid_report_to_key_matrix.sv */
// Top level of the HID boot keyboard report to 8x5 key matrix converter.
// Depends on hrkm_pkg, hrkm_lane, hrkm_merge and hid_report_to_key_matrix_assert.svh.
//
// Takes one request (modifier byte, six key codes, num-lock flag) in every
// clock cycle: busy is always low, so a request is accepted whenever start is
// high. The eight active-low matrix rows leave the merge register, behind the
// stage 1 register, on out_row_0..out_row_7, marked by a one-cycle out_strobe;
// the receiver cannot stall, so capture the rows in that cycle. Stage 1 runs
// one ROM lane per key slot in parallel, stage 2 ANDs the lane results with the
// Ctrl/Shift contribution in the merge register. Write the column mask
// (cfg_wr_en, cfg_wr_data) only while no request is in flight.
module hid_report_to_key_matrix
  import hrkm_pkg::*;
#(
  parameter int KEYS_PER_REPORT = 6
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] in_modifier_bits,
  input  logic [7:0] in_key_code_0,
  input  logic [7:0] in_key_code_1,
  input  logic [7:0] in_key_code_2,
  input  logic [7:0] in_key_code_3,
  input  logic [7:0] in_key_code_4,
  input  logic [7:0] in_key_code_5,
  input  logic       in_num_lock,
  output logic       out_strobe,
  output logic [7:0] out_row_0,
  output logic [7:0] out_row_1,
  output logic [7:0] out_row_2,
  output logic [7:0] out_row_3,
  output logic [7:0] out_row_4,
  output logic [7:0] out_row_5,
  output logic [7:0] out_row_6,
  output logic [7:0] out_row_7
);

  `include "hid_report_to_key_matrix_assert.svh"

  // Column mask register
  row_t cm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cm_r <= ROW_IDLE;
    end else if (cfg_wr_en) begin
      cm_r <= cfg_wr_data;
    end
  end

  // Pipeline never stalls
  logic req_acc;
  assign busy    = 1'b0;
  assign req_acc = start && !busy;

  // Modifier decode
  logic ctrl;
  logic shift;
  assign ctrl  = in_modifier_bits[MOD_LCTRL] | in_modifier_bits[MOD_RCTRL];
  assign shift = in_modifier_bits[MOD_LSHIFT] | in_modifier_bits[MOD_RSHIFT];

  row_set_t mod_rows;
  always_comb begin
    mod_rows = '1;
    if (ctrl) begin
      mod_rows[CAPS_ROW] = CAPS_MASK & cm_r;
    end
    if (shift) begin
      mod_rows[SYM_ROW] = SYM_MASK & cm_r;
    end
  end

  // Gather the key slots; a slot is live only while no earlier slot held zero
  code_t codes [KEY_SLOTS];
  logic  slot_en [KEY_SLOTS];

  assign codes[0] = in_key_code_0;
  assign codes[1] = in_key_code_1;
  assign codes[2] = in_key_code_2;
  assign codes[3] = in_key_code_3;
  assign codes[4] = in_key_code_4;
  assign codes[5] = in_key_code_5;

  always_comb begin
    slot_en[0] = (codes[0] != '0);
    for (int i = 1; i < KEY_SLOTS; i++) begin
      slot_en[i] = slot_en[i-1] && (codes[i] != '0);
    end
  end

  // Lanes: one ROM lookup per key slot, side by side
  row_set_t lane_rows [KEYS_PER_REPORT];

  for (genvar g = 0; g < KEYS_PER_REPORT; g++) begin : g_lane
    hrkm_lane u_lane (
      .lane_en     (slot_en[g]),
      .key_code    (codes[g]),
      .shift       (shift),
      .num_lock    (in_num_lock),
      .column_mask (cm_r),
      .lane_rows   (lane_rows[g])
    );
  end

  // Stage 1 register: hold lane and modifier masks for the merge
  row_set_t lane_rows_r [KEYS_PER_REPORT];
  row_set_t mod_rows_r;
  logic     stg1_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg1_vld_r <= 1'b0;
    end else begin
      stg1_vld_r <= req_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (req_acc) begin
      lane_rows_r <= lane_rows;
      mod_rows_r  <= mod_rows;
    end
  end

  // Stage 2: merge the lanes into the output register
  row_set_t rows;

  hrkm_merge #(
    .LANES (KEYS_PER_REPORT)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (stg1_vld_r),
    .mod_rows  (mod_rows_r),
    .lane_rows (lane_rows_r),
    .out_vld   (out_strobe),
    .out_rows  (rows)
  );

  assign out_row_0 = rows[0];
  assign out_row_1 = rows[1];
  assign out_row_2 = rows[2];
  assign out_row_3 = rows[3];
  assign out_row_4 = rows[4];
  assign out_row_5 = rows[5];
  assign out_row_6 = rows[6];
  assign out_row_7 = rows[7];

  // Every accepted request leaves the merge register in the cycle after stage 1
  `HRKM_ASSERT_NEXT(a_stg1_to_out, stg1_vld_r, out_strobe)
  `HRKM_ASSERT_NEXT(a_no_spurious_out, !stg1_vld_r, !out_strobe)
  // A held Ctrl always presses caps shift, whatever the column mask
  `HRKM_ASSERT_IMP(a_ctrl_caps, out_strobe && $past(req_acc && ctrl, 2), !out_row_7[0])
  // A held Shift always presses symbol shift
  `HRKM_ASSERT_IMP(a_shift_sym, out_strobe && $past(req_acc && shift, 2), !out_row_0[1])
  // An empty report with no modifiers presses nothing
  `HRKM_ASSERT_IMP(a_empty_idle,
    out_strobe && $past(req_acc && !ctrl && !shift && (in_key_code_0 == '0), 2),
    (&out_row_0) && (&out_row_1) && (&out_row_2) && (&out_row_3) &&
    (&out_row_4) && (&out_row_5) && (&out_row_6) && (&out_row_7))

endmodule

/* tb/key_matrix_board_pkg.sv */
// Scoreboard for the HID report to key matrix converter: expected row sets and their check.
// Depends on hrkm_pkg for the row, code and key cell types.
package key_matrix_board_pkg;
  import hrkm_pkg::*;

  typedef struct packed {
    row_t                   mods;
    code_t [KEY_SLOTS-1:0]  keys;
    logic                   num_lock;
  } hid_report_t;

  localparam code_t SHIFT_DIGIT_BASE = 8'hE8;
  localparam code_t SHIFT_PUNCT_BASE = 8'hF2;
  localparam code_t KEYPAD_BASE      = 8'hA5;

  class key_matrix_board;
    row_t        column_mask;
    row_set_t    pending_rows[$];
    int unsigned failures;

    function new();
      column_mask = ROW_IDLE;
      failures    = 0;
    endfunction

    static function rom_ent_t key_cell(code_t code);
      rom_ent_t c;
      c = '{1'b0, 3'd0, ROW_IDLE, SEC_NONE};
      case (code)
        8'h00: c = '{1'b1, 3'd0, 8'hFF, SEC_NONE};
        8'h04: c = '{1'b1, 3'd6, 8'hFE, SEC_NONE};
        8'h05: c = '{1'b1, 3'd0, 8'hEF, SEC_NONE};
        8'h06: c = '{1'b1, 3'd7, 8'hF7, SEC_NONE};
        8'h07: c = '{1'b1, 3'd6, 8'hFB, SEC_NONE};
        8'h08: c = '{1'b1, 3'd5, 8'hFB, SEC_NONE};
        8'h09: c = '{1'b1, 3'd6, 8'hF7, SEC_NONE};
        8'h0A: c = '{1'b1, 3'd6, 8'hEF, SEC_NONE};
        8'h0B: c = '{1'b1, 3'd1, 8'hEF, SEC_NONE};
        8'h0C: c = '{1'b1, 3'd2, 8'hFB, SEC_NONE};
        8'h0D: c = '{1'b1, 3'd1, 8'hF7, SEC_NONE};
        8'h0E: c = '{1'b1, 3'd1, 8'hFB, SEC_NONE};
        8'h0F: c = '{1'b1, 3'd1, 8'hFD, SEC_NONE};
        8'h10: c = '{1'b1, 3'd0, 8'hFB, SEC_NONE};
        8'h11: c = '{1'b1, 3'd0, 8'hF7, SEC_NONE};
        8'h12: c = '{1'b1, 3'd2, 8'hFD, SEC_NONE};
        8'h13: c = '{1'b1, 3'd2, 8'hFE, SEC_NONE};
        8'h14: c = '{1'b1, 3'd5, 8'hFE, SEC_NONE};
        8'h15: c = '{1'b1, 3'd5, 8'hF7, SEC_NONE};
        8'h16: c = '{1'b1, 3'd6, 8'hFD, SEC_NONE};
        8'h17: c = '{1'b1, 3'd5, 8'hEF, SEC_NONE};
        8'h18: c = '{1'b1, 3'd2, 8'hF7, SEC_NONE};
        8'h19: c = '{1'b1, 3'd7, 8'hEF, SEC_NONE};
        8'h1A: c = '{1'b1, 3'd5, 8'hFD, SEC_NONE};
        8'h1B: c = '{1'b1, 3'd7, 8'hFB, SEC_NONE};
        8'h1C: c = '{1'b1, 3'd2, 8'hEF, SEC_NONE};
        8'h1D: c = '{1'b1, 3'd7, 8'hFD, SEC_NONE};
        8'h1E: c = '{1'b1, 3'd4, 8'hFE, SEC_NONE};
        8'h1F: c = '{1'b1, 3'd4, 8'hFD, SEC_NONE};
        8'h20: c = '{1'b1, 3'd4, 8'hFB, SEC_NONE};
        8'h21: c = '{1'b1, 3'd4, 8'hF7, SEC_NONE};
        8'h22: c = '{1'b1, 3'd4, 8'hEF, SEC_NONE};
        8'h23: c = '{1'b1, 3'd3, 8'hEF, SEC_NONE};
        8'h24: c = '{1'b1, 3'd3, 8'hF7, SEC_NONE};
        8'h25: c = '{1'b1, 3'd3, 8'hFB, SEC_NONE};
        8'h26: c = '{1'b1, 3'd3, 8'hFD, SEC_NONE};
        8'h27: c = '{1'b1, 3'd3, 8'hFE, SEC_NONE};
        8'h28: c = '{1'b1, 3'd1, 8'hFE, SEC_NONE};
        8'h2A: c = '{1'b1, 3'd3, 8'hFE, SEC_CAPS};
        8'h2C: c = '{1'b1, 3'd0, 8'hFE, SEC_NONE};
        8'h2D: c = '{1'b1, 3'd1, 8'hF7, SEC_SYM};
        8'h2E: c = '{1'b1, 3'd1, 8'hFD, SEC_SYM};
        8'h2F: c = '{1'b1, 3'd2, 8'hEF, SEC_SYM};
        8'h30: c = '{1'b1, 3'd2, 8'hF7, SEC_SYM};
        8'h32: c = '{1'b1, 3'd2, 8'hFE, SEC_SYM};
        8'h33: c = '{1'b1, 3'd2, 8'hFD, SEC_SYM};
        8'h34: c = '{1'b1, 3'd3, 8'hF7, SEC_SYM};
        8'h35: c = '{1'b1, 3'd7, 8'hFB, SEC_SYM};
        8'h36: c = '{1'b1, 3'd0, 8'hF7, SEC_SYM};
        8'h37: c = '{1'b1, 3'd0, 8'hFB, SEC_SYM};
        8'h38: c = '{1'b1, 3'd7, 8'hEF, SEC_SYM};
        8'h4B: c = '{1'b1, 3'd0, 8'hFE, SEC_CAPS};
        8'h4F: c = '{1'b1, 3'd3, 8'hFB, SEC_CAPS};
        8'h50: c = '{1'b1, 3'd4, 8'hEF, SEC_CAPS};
        8'h51: c = '{1'b1, 3'd3, 8'hEF, SEC_CAPS};
        8'h52: c = '{1'b1, 3'd3, 8'hF7, SEC_CAPS};
        8'h54: c = '{1'b1, 3'd7, 8'hEF, SEC_SYM};
        8'h55: c = '{1'b1, 3'd0, 8'hEF, SEC_SYM};
        8'h56: c = '{1'b1, 3'd1, 8'hF7, SEC_SYM};
        8'h57: c = '{1'b1, 3'd1, 8'hFB, SEC_SYM};
        8'h58: c = '{1'b1, 3'd1, 8'hFE, SEC_NONE};
        8'hE8: c = '{1'b1, 3'd4, 8'hFE, SEC_SYM};
        8'hE9: c = '{1'b1, 3'd4, 8'hFD, SEC_SYM};
        8'hEA: c = '{1'b1, 3'd4, 8'hFB, SEC_SYM};
        8'hEB: c = '{1'b1, 3'd4, 8'hF7, SEC_SYM};
        8'hEC: c = '{1'b1, 3'd4, 8'hEF, SEC_SYM};
        8'hED: c = '{1'b1, 3'd1, 8'hEF, SEC_SYM};
        8'hEE: c = '{1'b1, 3'd3, 8'hEF, SEC_SYM};
        8'hEF: c = '{1'b1, 3'd0, 8'hEF, SEC_SYM};
        8'hF0: c = '{1'b1, 3'd3, 8'hFB, SEC_SYM};
        8'hF1: c = '{1'b1, 3'd3, 8'hFD, SEC_SYM};
        8'hF2: c = '{1'b1, 3'd3, 8'hFE, SEC_SYM};
        8'hF3: c = '{1'b1, 3'd1, 8'hFB, SEC_SYM};
        8'hF4: c = '{1'b1, 3'd6, 8'hF7, SEC_SYM};
        8'hF5: c = '{1'b1, 3'd6, 8'hEF, SEC_SYM};
        8'hF7: c = '{1'b1, 3'd6, 8'hFD, SEC_SYM};
        8'hF8: c = '{1'b1, 3'd7, 8'hFD, SEC_SYM};
        8'hF9: c = '{1'b1, 3'd2, 8'hFE, SEC_SYM};
        8'hFA: c = '{1'b1, 3'd6, 8'hFE, SEC_SYM};
        8'hFB: c = '{1'b1, 3'd5, 8'hF7, SEC_SYM};
        8'hFC: c = '{1'b1, 3'd0, 8'hFB, SEC_SYM};
        8'hFD: c = '{1'b1, 3'd7, 8'hF7, SEC_SYM};
        default: c.hit = 1'b0;
      endcase
      return c;
    endfunction

    static function code_t shift_code(code_t code, logic shift, logic num_lock);
      if (shift) begin
        if (code >= DIGIT_LO && code <= DIGIT_HI) return code - DIGIT_LO + SHIFT_DIGIT_BASE;
        if (code >= PUNCT_LO && code <= PUNCT_HI) return code - PUNCT_LO + SHIFT_PUNCT_BASE;
      end else if (num_lock && code >= KPAD_LO && code <= KPAD_HI) begin
        return code - KPAD_LO + KEYPAD_BASE;
      end
      return code;
    endfunction

    function row_set_t translate(hid_report_t r);
      row_set_t rows;
      logic     ctrl;
      logic     shift;
      logic     stop;
      rom_ent_t c;
      rows  = {ROW_COUNT{ROW_IDLE}};
      ctrl  = r.mods[MOD_LCTRL] | r.mods[MOD_RCTRL];
      shift = r.mods[MOD_LSHIFT] | r.mods[MOD_RSHIFT];
      if (ctrl) rows[CAPS_ROW] &= CAPS_MASK & column_mask;
      if (shift) rows[SYM_ROW] &= SYM_MASK & column_mask;
      stop = 1'b0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        if (r.keys[i] == '0) stop = 1'b1;
        if (!stop) begin
          c = key_cell(shift_code(r.keys[i], shift, r.num_lock));
          if (c.hit) begin
            rows[c.row] &= c.mask & column_mask;
            case (c.sec)
              SEC_CAPS: rows[CAPS_ROW] &= CAPS_MASK & column_mask;
              SEC_SYM:  rows[SYM_ROW] &= SYM_MASK & column_mask;
              default: ;
            endcase
          end
        end
      end
      return rows;
    endfunction

    function void note_request(hid_report_t r);
      pending_rows.push_back(translate(r));
    endfunction

    function void check_rows(row_set_t got);
      row_set_t want;
      if (pending_rows.size() == 0) begin
        $error("row set 0x%016h arrived with no pending request", got);
        failures++;
        return;
      end
      want = pending_rows.pop_front();
      for (int r = 0; r < ROW_COUNT; r++) begin
        if (got[r] !== want[r]) begin
          $error("row_%0d expected 0x%02h actual 0x%02h", r, want[r], got[r]);
          failures++;
        end
      end
    endfunction

    function int pending_count();
      return pending_rows.size();
    endfunction
  endclass

endpackage

/* tb/tb.sv */
// Top-level testbench for hid_report_to_key_matrix: directed and random keyboard reports.
// Depends on hrkm_pkg and key_matrix_board_pkg; drives requests and checks every row set.
module tb
  import hrkm_pkg::*;
  import key_matrix_board_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 200;
  localparam int SETTLE_CYCLES = 6;    // pipeline is two deep; leave some margin
  localparam int DRAIN_LIMIT   = 200;

  logic       clk;
  logic       rst_n;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;
  logic       start;
  logic       busy;
  logic [7:0] in_modifier_bits;
  logic [7:0] in_key_code_0;
  logic [7:0] in_key_code_1;
  logic [7:0] in_key_code_2;
  logic [7:0] in_key_code_3;
  logic [7:0] in_key_code_4;
  logic [7:0] in_key_code_5;
  logic       in_num_lock;
  logic       out_strobe;
  logic [7:0] out_row_0;
  logic [7:0] out_row_1;
  logic [7:0] out_row_2;
  logic [7:0] out_row_3;
  logic [7:0] out_row_4;
  logic [7:0] out_row_5;
  logic [7:0] out_row_6;
  logic [7:0] out_row_7;

  key_matrix_board board = new();

  hid_report_to_key_matrix dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .start            (start),
    .busy             (busy),
    .in_modifier_bits (in_modifier_bits),
    .in_key_code_0    (in_key_code_0),
    .in_key_code_1    (in_key_code_1),
    .in_key_code_2    (in_key_code_2),
    .in_key_code_3    (in_key_code_3),
    .in_key_code_4    (in_key_code_4),
    .in_key_code_5    (in_key_code_5),
    .in_num_lock      (in_num_lock),
    .out_strobe       (out_strobe),
    .out_row_0        (out_row_0),
    .out_row_1        (out_row_1),
    .out_row_2        (out_row_2),
    .out_row_3        (out_row_3),
    .out_row_4        (out_row_4),
    .out_row_5        (out_row_5),
    .out_row_6        (out_row_6),
    .out_row_7        (out_row_7)
  );

  // 2 ns clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: fails the run if it has not finished in time.
  initial begin
    #200000;
    $display("hid_report_to_key_matrix test failed");
    $finish;
  end

  // Sample at the rising edge, before any driver update of this step lands.
  // Note an accepted request first; its rows cannot show up in the same cycle.
  always @(posedge clk) begin : watch
    hid_report_t seen;
    if (rst_n) begin
      if (start && !busy) begin
        seen.mods     = in_modifier_bits;
        seen.keys     = {in_key_code_5, in_key_code_4, in_key_code_3,
                         in_key_code_2, in_key_code_1, in_key_code_0};
        seen.num_lock = in_num_lock;
        board.note_request(seen);
      end
      if (out_strobe) begin
        board.check_rows({out_row_7, out_row_6, out_row_5, out_row_4,
                          out_row_3, out_row_2, out_row_1, out_row_0});
      end
    end
  end

  function automatic hid_report_t make_report(row_t mods, code_t k0, code_t k1, code_t k2,
                                              code_t k3, code_t k4, code_t k5, logic num);
    hid_report_t r;
    r.mods     = mods;
    r.keys     = {k5, k4, k3, k2, k1, k0};
    r.num_lock = num;
    return r;
  endfunction

  // Bias codes toward the ones the table knows and the remap windows.
  function automatic code_t pick_code();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 40) return code_t'($urandom_range(8'h38, 8'h1E));
    if (sel < 60) return code_t'($urandom_range(8'h1D, 8'h04));
    if (sel < 75) return code_t'($urandom_range(8'h63, 8'h4B));
    if (sel < 85) return code_t'($urandom_range(8'hFD, 8'hE8));
    return code_t'($urandom_range(255, 1));
  endfunction

  // Mostly well-formed reports (keys packed in front, then a zero), some raw noise.
  function automatic hid_report_t random_report();
    hid_report_t r;
    int unsigned n;
    case ($urandom_range(3))
      0:       r.mods = '0;
      1:       r.mods = row_t'($urandom_range(255)) & 8'h33;
      default: r.mods = row_t'($urandom_range(255));
    endcase
    r.num_lock = logic'($urandom_range(1));
    r.keys     = '0;
    if ($urandom_range(99) < 85) begin
      n = $urandom_range(KEY_SLOTS);
      for (int i = 0; i < KEY_SLOTS; i++) begin
        if (i < n) r.keys[i] = pick_code();
        else if (i > n && $urandom_range(1)) r.keys[i] = code_t'($urandom_range(255));
      end
    end else begin
      for (int i = 0; i < KEY_SLOTS; i++) r.keys[i] = code_t'($urandom_range(255));
    end
    return r;
  endfunction

  // Present one request and hold it until accepted. Enter and leave on a rising edge.
  // Read busy at the falling edge, where it is stable.
  task automatic send_request(hid_report_t r);
    start            <= 1'b1;
    in_modifier_bits <= r.mods;
    in_key_code_0    <= r.keys[0];
    in_key_code_1    <= r.keys[1];
    in_key_code_2    <= r.keys[2];
    in_key_code_3    <= r.keys[3];
    in_key_code_4    <= r.keys[4];
    in_key_code_5    <= r.keys[5];
    in_num_lock      <= r.num_lock;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  // Drop start for a random number of cycles, each taken with the given odds.
  task automatic idle_gap(int unsigned pct);
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Drop start, wait for every pending row set, then let the pipeline settle.
  task automatic drain();
    int unsigned waited;
    start  <= 1'b0;
    waited = 0;
    @(posedge clk);
    while (board.pending_count() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the column mask while idle; the predictor takes the value at once, before the DUT registers it.
  task automatic write_column_mask(row_t value);
    cfg_wr_en         <= 1'b1;
    cfg_wr_data       <= value;
    board.column_mask = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin : stimulus
    hid_report_t directed[$];
    row_t        masks[PHASES];
    int unsigned idle_pct[4];

    // Hold every input at a known value from time zero.
    rst_n            = 1'b0;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;
    start            = 1'b0;
    in_modifier_bits = '0;
    in_key_code_0    = '0;
    in_key_code_1    = '0;
    in_key_code_2    = '0;
    in_key_code_3    = '0;
    in_key_code_4    = '0;
    in_key_code_5    = '0;
    in_num_lock      = 1'b0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset column mask.
    directed.push_back(make_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
    directed.push_back(make_report(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1));
    // left ctrl, then right ctrl, alone
    directed.push_back(make_report(8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
    directed.push_back(make_report(8'h10, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
    // shifted digits at both window ends
    directed.push_back(make_report(8'h02, 8'h1E, 8'h27, 8'h22, 8'h23, 8'h00, 8'h00, 1'b0));
    // shifted punctuation, a hole in the window, caps secondary outside it
    directed.push_back(make_report(8'h20, 8'h2D, 8'h38, 8'h31, 8'h2A, 8'h00, 8'h00, 1'b0));
    directed.push_back(make_report(8'h00, 8'h1E, 8'h27, 8'h2D, 8'h38, 8'h00, 8'h00, 1'b0));
    // keypad with num lock lands on empty entries; the letter still presses
    directed.push_back(make_report(8'h00, 8'h59, 8'h63, 8'h5D, 8'h04, 8'h00, 8'h00, 1'b1));
    // shift blocks the keypad remap
    directed.push_back(make_report(8'h22, 8'h59, 8'h63, 8'h5D, 8'h04, 8'h00, 8'h00, 1'b1));
    directed.push_back(make_report(8'h00, 8'h59, 8'h63, 8'h58, 8'h00, 8'h00, 8'h00, 1'b0));
    // codes without an entry do not end the walk
    directed.push_back(make_report(8'h00, 8'h29, 8'h31, 8'h01, 8'h03, 8'h39, 8'h04, 1'b0));
    // keys after the first zero are ignored
    directed.push_back(make_report(8'h00, 8'h04, 8'h00, 8'h05, 8'h06, 8'h07, 8'h08, 1'b0));
    directed.push_back(make_report(8'h00, 8'h00, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 1'b0));
    // secondary caps-shift and symbol-shift entries
    directed.push_back(make_report(8'h00, 8'h4B, 8'h4F, 8'h50, 8'h51, 8'h52, 8'h00, 1'b0));
    directed.push_back(make_report(8'h00, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58, 8'h00, 1'b0));
    // upper table reached directly, plus its holes
    directed.push_back(make_report(8'h00, 8'hE8, 8'hFD, 8'hF6, 8'hA5, 8'hAF, 8'h00, 1'b0));
    directed.push_back(make_report(8'h11, 8'h04, 8'h16, 8'h1D, 8'h28, 8'h2C, 8'h0A, 1'b0));
    // modifier bits outside ctrl and shift do nothing
    directed.push_back(make_report(8'hCC, 8'h05, 8'h06, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
    directed.push_back(make_report(8'h33, 8'h1E, 8'h2D, 8'h59, 8'h04, 8'h2A, 8'h4B, 1'b1));

    foreach (directed[i]) send_request(directed[i]);
    drain();

    // Mask settings per phase: both extremes, a single bit clear, a single bit set and random values.
    masks    = '{8'h00, 8'hFF, row_t'($urandom_range(255)), 8'hFE,
                 row_t'($urandom_range(255)), 8'h01, row_t'($urandom_range(255)), 8'hFF};
    // Sender idle odds per phase: none, heavy, none (receiver cannot stall), light.
    idle_pct = '{0, 62, 0, 19};

    for (int p = 0; p < PHASES; p++) begin
      write_column_mask(masks[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        idle_gap(idle_pct[p % 4]);
        send_request(random_report());
      end
      drain();
    end

    if (board.pending_count() != 0) begin
      $error("%0d row sets never arrived", board.pending_count());
      board.failures++;
    end

    if (board.failures == 0) begin
      $display("hid_report_to_key_matrix test passed");
    end else begin
      $display("hid_report_to_key_matrix test failed");
    end
    $finish;
  end

endmodule
